[hw/rtl/hex_lattice_snap_exact_core_macros.svh]
// Assertion macros for the hex lattice snap checker.
`ifndef HEX_LATTICE_SNAP_EXACT_CORE_MACROS_SVH
`define HEX_LATTICE_SNAP_EXACT_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define HLSE_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define HLSE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[hw/rtl/hlse_pkg.sv]
// Shared constants, types and candidate offsets for the hex lattice snap.
`default_nettype none

package hlse_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COORD_WIDTH = 32;
	localparam int OUT_WIDTH   = 17;
	localparam int PIPE_DEPTH  = 11;

	// sqrt(3)/2 in Q32, and 2/sqrt(3) in Q32 less its integer part
	localparam logic [31:0] SQRT3_HALF_Q32 = 32'd3719550787;
	localparam logic [29:0] INV_LO_Q32     = 30'd664433753;

	localparam int B_SHIFT = FRAC_BITS + 32;
	localparam int A_SHIFT = FRAC_BITS + 33;
	localparam int Q_SHIFT = 32 - FRAC_BITS;

	localparam int YK_W  = COORD_WIDTH + 31;
	localparam int BR_W  = COORD_WIDTH + 34;
	localparam int AR_W  = COORD_WIDTH + 35;
	localparam int CO_W  = BR_W - B_SHIFT;
	localparam int BS_W  = CO_W + 33;
	localparam int WX_W  = CO_W + 34;
	localparam int DD_W  = 36;
	localparam int SPLIT = 17;
	localparam int PH_W  = DD_W - SPLIT + 33;
	localparam int PL_W  = SPLIT + 32;
	localparam int P_W   = 66;
	localparam int X3_W  = DD_W + 2;
	localparam int DW    = 70;

	localparam logic signed [DW-1:0] Q62   = DW'(64'h4000_0000_0000_0000);
	localparam logic signed [DW-1:0] Q62X4 = Q62 <<< 2;
	localparam logic signed [DW-1:0] S_SQ  = DW'(SQRT3_HALF_Q32) * DW'(SQRT3_HALF_Q32);
	localparam logic signed [DW-1:0] K1    = Q62 + S_SQ;
	localparam logic signed [DW-1:0] K9    = Q62 + (Q62 <<< 3) + S_SQ;

	// candidate codes, in tie-break order
	localparam logic [2:0] C_START = 3'd0;
	localparam logic [2:0] C_PA    = 3'd1;
	localparam logic [2:0] C_PB    = 3'd2;
	localparam logic [2:0] C_MAPB  = 3'd3;
	localparam logic [2:0] C_MA    = 3'd4;
	localparam logic [2:0] C_MB    = 3'd5;
	localparam logic [2:0] C_PAMB  = 3'd6;

	typedef struct packed {
		logic signed [DW-1:0] delta;
		logic [2:0]           idx;
	} cand_t;

	function automatic logic signed [1:0] nbr_da(input logic [2:0] idx);
		logic signed [1:0] r;
		unique case (idx)
			C_PA, C_PAMB: r = 2'sd1;
			C_MAPB, C_MA: r = -2'sd1;
			default:      r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] nbr_db(input logic [2:0] idx);
		logic signed [1:0] r;
		unique case (idx)
			C_PB, C_MAPB: r = 2'sd1;
			C_MB, C_PAMB: r = -2'sd1;
			default:      r = 2'sd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/hex_lattice_snap_exact_core.sv]
// Hex lattice snap: pipelined nearest Eisenstein lattice point of a Q16.16 point.
// Takes one point per cycle while point_stall is low and returns (a, b) through the
// chain of stages: reciprocal multiply, b/a rounding, candidate offsets, the split
// sqrt(3)/2 multiply, the six distance deltas and a three-level compare tree;
// throughput is one item per clock while the result side does not stall. Each
// stage holds while the one after it is full and stalled, so bubbles are squeezed out
// and nothing is dropped or repeated. The block has no state beyond the pipeline.
`default_nettype none

module hex_lattice_snap_exact_core import hlse_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          snap_valid,
	input  logic                          snap_stall,
	output logic signed [OUT_WIDTH-1:0]   lattice_a,
	output logic signed [OUT_WIDTH-1:0]   lattice_b
);

	localparam logic signed [BR_W-1:0] HALF_B = BR_W'(1) <<< (B_SHIFT - 1);
	localparam logic signed [AR_W-1:0] HALF_A = AR_W'(1) <<< (A_SHIFT - 1);

	logic [PIPE_DEPTH:1] vld_q;
	logic [PIPE_DEPTH:1] stg_en;
	logic [PIPE_DEPTH:1] vld_in;

	always_comb begin
		stg_en[PIPE_DEPTH] = !vld_q[PIPE_DEPTH] || !snap_stall;
		for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
			stg_en[k] = !vld_q[k] || stg_en[k+1];
		end
	end

	assign vld_in      = {vld_q[PIPE_DEPTH-1:1], point_valid};
	assign point_stall = !stg_en[1];
	assign snap_valid  = vld_q[PIPE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= PIPE_DEPTH; k++) begin
				if (stg_en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// s1: y times the fractional part of 2/sqrt(3)
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1;
	logic signed [YK_W-1:0]        yk_s1;

	always_ff @(posedge clk) begin
		if (stg_en[1]) begin
			x_s1  <= point_x;
			y_s1  <= point_y;
			yk_s1 <= point_y * $signed({1'b0, INV_LO_Q32});
		end
	end

	// s2: b_raw = y * 2/sqrt(3), Q48
	logic signed [COORD_WIDTH-1:0] x_s2;
	logic signed [BR_W-1:0]        braw_s2;

	always_ff @(posedge clk) begin
		if (stg_en[2]) begin
			x_s2    <= x_s1;
			braw_s2 <= (BR_W'(y_s1) <<< 32) + BR_W'(yk_s1);
		end
	end

	// s3: round b, form a_raw = x + b_raw/2 in Q49
	logic signed [BR_W-1:0]        b_sum;
	logic signed [COORD_WIDTH-1:0] x_s3, y_s3;
	logic signed [CO_W-1:0]        b0_s3;
	logic signed [AR_W-1:0]        araw_s3;
	logic signed [COORD_WIDTH-1:0] y_s2;

	// half away from zero: negative values take half less one lsb, then floor
	assign b_sum = braw_s2 + (braw_s2[BR_W-1] ? HALF_B - BR_W'(1) : HALF_B);

	always_ff @(posedge clk) begin
		if (stg_en[2]) begin
			y_s2 <= y_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (stg_en[3]) begin
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			b0_s3   <= b_sum[BR_W-1:B_SHIFT];
			araw_s3 <= (AR_W'(x_s2) <<< 33) + AR_W'(braw_s2);
		end
	end

	// s4: round a, b * sqrt(3)/2
	logic signed [AR_W-1:0]        a_sum;
	logic signed [COORD_WIDTH-1:0] x_s4, y_s4;
	logic signed [CO_W-1:0]        a0_s4, b0_s4;
	logic signed [BS_W-1:0]        bs_s4;

	assign a_sum = araw_s3 + (araw_s3[AR_W-1] ? HALF_A - AR_W'(1) : HALF_A);

	always_ff @(posedge clk) begin
		if (stg_en[4]) begin
			x_s4  <= x_s3;
			y_s4  <= y_s3;
			a0_s4 <= a_sum[AR_W-1:A_SHIFT];
			b0_s4 <= b0_s3;
			bs_s4 <= b0_s3 * $signed({1'b0, SQRT3_HALF_Q32});
		end
	end

	// s5: offsets of the start point, Q32; both stay well inside DD_W
	logic signed [WX_W-1:0] dx_full, dy_full;
	logic signed [DD_W-1:0] dx0_s5, dy0_s5;
	logic signed [CO_W-1:0] a0_s5, b0_s5;

	assign dx_full = (WX_W'(x_s4) <<< Q_SHIFT) - (WX_W'(a0_s4) <<< 32)
		+ (WX_W'(b0_s4) <<< 31);
	assign dy_full = (WX_W'(y_s4) <<< Q_SHIFT) - WX_W'(bs_s4);

	always_ff @(posedge clk) begin
		if (stg_en[5]) begin
			dx0_s5 <= dx_full[DD_W-1:0];
			dy0_s5 <= dy_full[DD_W-1:0];
			a0_s5  <= a0_s4;
			b0_s5  <= b0_s4;
		end
	end

	// s6: dy0 * sqrt(3)/2 in two partial products
	logic signed [PH_W-1:0] ph_s6;
	logic [PL_W-1:0]        pl_s6;
	logic signed [DD_W-1:0] dx0_s6;
	logic signed [CO_W-1:0] a0_s6, b0_s6;

	always_ff @(posedge clk) begin
		if (stg_en[6]) begin
			ph_s6  <= $signed(dy0_s5[DD_W-1:SPLIT]) * $signed({1'b0, SQRT3_HALF_Q32});
			pl_s6  <= dy0_s5[SPLIT-1:0] * SQRT3_HALF_Q32;
			dx0_s6 <= dx0_s5;
			a0_s6  <= a0_s5;
			b0_s6  <= b0_s5;
		end
	end

	// s7: join the partial products, 3 * dx0
	logic signed [P_W-1:0]  p_s7;
	logic signed [DD_W-1:0] dx0_s7;
	logic signed [X3_W-1:0] dx3_s7;
	logic signed [CO_W-1:0] a0_s7, b0_s7;

	always_ff @(posedge clk) begin
		if (stg_en[7]) begin
			p_s7   <= (P_W'(ph_s6) <<< SPLIT) + P_W'($signed({1'b0, pl_s6}));
			dx0_s7 <= dx0_s6;
			dx3_s7 <= X3_W'(dx0_s6) + (X3_W'(dx0_s6) <<< 1);
			a0_s7  <= a0_s6;
			b0_s7  <= b0_s6;
		end
	end

	// s8: squared distance of each neighbour minus that of the start
	logic signed [DW-1:0] t1, t2, t3, p2;
	logic signed [DW-1:0] dist_s8 [1:6];
	logic signed [CO_W-1:0] a0_s8, b0_s8;

	assign t1 = DW'(dx0_s7) <<< 32;
	assign t2 = DW'(dx0_s7) <<< 33;
	assign t3 = DW'(dx3_s7) <<< 32;
	assign p2 = DW'(p_s7) <<< 1;

	always_ff @(posedge clk) begin
		if (stg_en[8]) begin
			dist_s8[1] <= Q62X4 - t2;
			dist_s8[2] <= K1 + t1 - p2;
			dist_s8[3] <= K9 + t3 - p2;
			dist_s8[4] <= Q62X4 + t2;
			dist_s8[5] <= K1 + p2 - t1;
			dist_s8[6] <= K9 + p2 - t3;
			a0_s8      <= a0_s7;
			b0_s8      <= b0_s7;
		end
	end

	// s9..s11: compare tree; the later candidate wins only when strictly closer
	cand_t                  w01_s9, w23_s9, w45_s9;
	logic signed [DW-1:0]   d6_s9;
	logic signed [CO_W-1:0] a0_s9, b0_s9;

	always_ff @(posedge clk) begin
		if (stg_en[9]) begin
			w01_s9 <= dist_s8[1][DW-1] ? '{dist_s8[1], C_PA} : '{'0, C_START};
			w23_s9 <= (dist_s8[3] < dist_s8[2]) ? '{dist_s8[3], C_MAPB}
				: '{dist_s8[2], C_PB};
			w45_s9 <= (dist_s8[5] < dist_s8[4]) ? '{dist_s8[5], C_MB}
				: '{dist_s8[4], C_MA};
			d6_s9  <= dist_s8[6];
			a0_s9  <= a0_s8;
			b0_s9  <= b0_s8;
		end
	end

	cand_t                  wa_s10, wb_s10;
	logic signed [CO_W-1:0] a0_s10, b0_s10;

	always_ff @(posedge clk) begin
		if (stg_en[10]) begin
			wa_s10 <= (w23_s9.delta < w01_s9.delta) ? w23_s9 : w01_s9;
			wb_s10 <= (d6_s9 < w45_s9.delta) ? '{d6_s9, C_PAMB} : w45_s9;
			a0_s10 <= a0_s9;
			b0_s10 <= b0_s9;
		end
	end

	cand_t                  win;
	logic signed [CO_W-1:0] a_fin, b_fin;

	assign win   = (wb_s10.delta < wa_s10.delta) ? wb_s10 : wa_s10;
	assign a_fin = a0_s10 + CO_W'(nbr_da(win.idx));
	assign b_fin = b0_s10 + CO_W'(nbr_db(win.idx));

	logic signed [OUT_WIDTH-1:0] a_s11, b_s11;

	always_ff @(posedge clk) begin
		if (stg_en[11]) begin
			a_s11 <= a_fin[OUT_WIDTH-1:0];
			b_s11 <= b_fin[OUT_WIDTH-1:0];
		end
	end

	assign lattice_a = a_s11;
	assign lattice_b = b_s11;

endmodule

`default_nettype wire

[hw/rtl/hlse_chk.sv]
// Port-level checker for the hex lattice snap core, bound to the core module.
`default_nettype none

`include "hex_lattice_snap_exact_core_macros.svh"

module hlse_chk import hlse_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        point_valid,
	input logic                        point_stall,
	input logic                        snap_valid,
	input logic                        snap_stall,
	input logic signed [OUT_WIDTH-1:0] lattice_a,
	input logic signed [OUT_WIDTH-1:0] lattice_b
);

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic             in_acc, out_acc;
	logic [CNT_W-1:0] cnt_q;

	assign in_acc  = point_valid && !point_stall;
	assign out_acc = snap_valid && !snap_stall;

	// items in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	`HLSE_ASSERT_NEXT(a_out_hold, snap_valid && snap_stall, snap_valid && $stable(lattice_a) && $stable(lattice_b), "result changed while stalled")
	`HLSE_ASSERT_NOW(a_no_orphan, snap_valid, cnt_q != '0, "result with no item in flight")
	`HLSE_ASSERT_NOW(a_depth, 1'b1, cnt_q <= CNT_W'(PIPE_DEPTH), "more items in flight than stages")
	`HLSE_ASSERT_NOW(a_full_stall, (cnt_q == CNT_W'(PIPE_DEPTH)) && snap_stall, point_stall, "full and stalled pipe took an item")

endmodule

bind hex_lattice_snap_exact_core hlse_chk u_hlse_chk (.*);

`default_nettype wire

[verif/tb_top.sv]
// Self-checking bench for the hex lattice snap core: directed and random points, scoreboarded.
`timescale 1ns / 100ps

module tb_top;
	import hlse_pkg::*;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] a;
		logic signed [OUT_WIDTH-1:0] b;
	} snap_t;

	localparam int     N_RANDOM    = 1900;
	localparam int     CYCLE_LIMIT = 200000;
	localparam int     HOLD_AT     = 1400;
	localparam int     HOLD_CYCLES = 300;
	localparam int     PHASE_LEN   = 640;
	localparam longint ROOT3_HALF_Q32     = 64'sd3719550787;
	localparam logic signed [127:0] INV_ROOT3_X2_Q32 = 128'sd4959401049;

	// Q16.16 helpers for building points near the lattice
	localparam int HALF_Q16     = 32768;
	localparam int QUARTER_Q16  = 16384;
	localparam int ROW_Q16      = 56756;  // sqrt(3)/2
	localparam int HOLE_Q16     = 18919;  // sqrt(3)/6
	localparam int EDGE_Q16     = 28378;  // sqrt(3)/4
	localparam int TWO_HOLE_Q16 = 37837;  // sqrt(3)/3

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   point_valid = 1'b0;
	logic   point_stall;
	coord_t point_x = '0;
	coord_t point_y = '0;
	logic   snap_valid;
	logic   snap_stall = 1'b0;
	logic signed [OUT_WIDTH-1:0] lattice_a;
	logic signed [OUT_WIDTH-1:0] lattice_b;

	point_t point_queue[$];
	snap_t  snap_expected[$];

	int n_items = 0;
	int n_accepted = 0;
	int n_snaps = 0;
	int n_errors = 0;
	int cycles = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	hex_lattice_snap_exact_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.snap_valid (snap_valid),
		.snap_stall (snap_stall),
		.lattice_a  (lattice_a),
		.lattice_b  (lattice_b)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// --- golden arithmetic -------------------------------------------------

	function automatic longint round_half_away(input logic signed [127:0] v, input int p);
		logic neg;
		logic signed [127:0] m;
		longint q;
		neg = (v < 0);
		m = neg ? -v : v;
		m = (m + (128'sd1 <<< (p - 1))) >>> p;
		q = m[63:0];
		return neg ? -q : q;
	endfunction

	// squared distance in Q64 from (px, py) to lattice point (a, b)
	function automatic logic signed [127:0] hex_dist2(input coord_t px, input coord_t py,
			input longint a, input longint b);
		longint dx, dy;
		logic signed [127:0] wx, wy;
		dx = (longint'(px) <<< (32 - FRAC_BITS)) - (a <<< 32) + (b <<< 31);
		dy = (longint'(py) <<< (32 - FRAC_BITS)) - b * ROOT3_HALF_Q32;
		wx = dx;
		wy = dy;
		return wx * wx + wy * wy;
	endfunction

	function automatic snap_t nearest_hex_point(input coord_t px, input coord_t py);
		logic signed [127:0] xw, yw, b_raw, a_raw, best, d;
		longint a0, b0, na, nb, best_a, best_b, da, db;
		snap_t r;
		xw = px;
		yw = py;
		b_raw = yw * INV_ROOT3_X2_Q32;
		a_raw = (xw <<< 33) + b_raw;
		b0 = round_half_away(b_raw, FRAC_BITS + 32);
		a0 = round_half_away(a_raw, FRAC_BITS + 33);
		best_a = a0;
		best_b = b0;
		best = hex_dist2(px, py, a0, b0);
		// neighbours of the rounded start, strict compare keeps the earliest on a tie
		for (int k = 0; k < 6; k++) begin
			case (k)
				0: begin da = 1;  db = 0;  end
				1: begin da = 0;  db = 1;  end
				2: begin da = -1; db = 1;  end
				3: begin da = -1; db = 0;  end
				4: begin da = 0;  db = -1; end
				default: begin da = 1; db = -1; end
			endcase
			na = a0 + da;
			nb = b0 + db;
			d = hex_dist2(px, py, na, nb);
			if (d < best) begin
				best = d;
				best_a = na;
				best_b = nb;
			end
		end
		r.a = OUT_WIDTH'(best_a);
		r.b = OUT_WIDTH'(best_b);
		return r;
	endfunction

	// --- stimulus ----------------------------------------------------------

	function automatic int pick_sign(input int v);
		return $urandom_range(1) ? -v : v;
	endfunction

	task automatic queue_point(input coord_t px, input coord_t py);
		point_t p;
		p.x = px;
		p.y = py;
		point_queue.push_back(p);
		n_items++;
	endtask

	function automatic int send_idle_pct();
		if (n_accepted < PHASE_LEN)
			return 20;
		else if (n_accepted < 2 * PHASE_LEN)
			return 66;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (n_accepted < PHASE_LEN)
			return 66;
		else if (n_accepted < 2 * PHASE_LEN)
			return 20;
		return 0;
	endfunction

	initial begin
		int sel, la, lb, ox, oy, bx, by;

		// extremes, single lsbs, halfway rounding and equidistant points
		queue_point(32'sd0, 32'sd0);
		queue_point(32'h7FFFFFFF, 32'h7FFFFFFF);
		queue_point(32'h80000000, 32'h80000000);
		queue_point(32'h7FFFFFFF, 32'h80000000);
		queue_point(32'h80000000, 32'h7FFFFFFF);
		queue_point(32'sd1, 32'sd0);
		queue_point(32'sd0, 32'sd1);
		queue_point(-32'sd1, -32'sd1);
		queue_point(HALF_Q16, 32'sd0);
		queue_point(-HALF_Q16, 32'sd0);
		queue_point(HALF_Q16, HOLE_Q16);
		queue_point(-HALF_Q16, -HOLE_Q16);
		queue_point(QUARTER_Q16, EDGE_Q16);
		queue_point(-QUARTER_Q16, EDGE_Q16);
		queue_point(32'sd0, TWO_HOLE_Q16);
		queue_point(32'h7FFF8000, 32'sd0);
		queue_point(32'h80008000, 32'sd0);
		queue_point(32'h55555555, 32'hAAAAAAAA);
		queue_point(32'hAAAAAAAA, 32'h55555555);
		queue_point(3 * 65536, 2 * ROW_Q16);

		for (int i = 0; i < N_RANDOM; i++) begin
			sel = $urandom_range(99);
			la = int'($urandom_range(32000)) - 16000;
			lb = int'($urandom_range(32000)) - 16000;
			bx = (la <<< 16) - (lb <<< 15);
			by = lb * ROW_Q16;
			if (sel < 30) begin
				queue_point($urandom, $urandom);
			end else if (sel < 55) begin
				// close to a lattice point
				queue_point(bx + int'($urandom_range(80000)) - 40000,
					by + int'($urandom_range(80000)) - 40000);
			end else if (sel < 85) begin
				// on or next to a cell edge or a deep hole
				case ($urandom_range(3))
					0: begin ox = pick_sign(HALF_Q16);    oy = 0; end
					1: begin ox = pick_sign(QUARTER_Q16); oy = pick_sign(EDGE_Q16); end
					2: begin ox = pick_sign(HALF_Q16);    oy = pick_sign(HOLE_Q16); end
					default: begin ox = 0; oy = pick_sign(TWO_HOLE_Q16); end
				endcase
				queue_point(bx + ox + int'($urandom_range(4)) - 2,
					by + oy + int'($urandom_range(4)) - 2);
			end else begin
				// tiny values, some with an exact half in x
				ox = int'($urandom_range(140000)) - 70000;
				if ($urandom_range(1))
					ox = (ox & ~32'hFFFF) | HALF_Q16;
				queue_point(ox, int'($urandom_range(140000)) - 70000);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted != n_items)
			@(posedge clk);
		while (snap_expected.size() != 0)
			@(posedge clk);
		repeat (3 * PIPE_DEPTH) @(posedge clk);

		$display("%0d points sent, %0d snaps checked, %0d mismatches", n_items, n_snaps,
			n_errors);
		$display("covered: extremes, halfway rounding, edge and hole ties, random points, "
			, "three idling mixes and one long result hold-off");
		if (n_errors == 0 && n_snaps == n_items) begin
			$display("hex_lattice_snap_exact_core verification clean");
		end else begin
			$display("hex_lattice_snap_exact_core verification failed");
		end
		$finish;
	end

	// --- driver: offers points, holds a stalled item steady -----------------

	always @(posedge clk) begin
		logic take_next;
		point_t p;
		if (arst_n) begin
			take_next = !point_valid;
			if (point_valid && !point_stall) begin
				snap_expected.push_back(nearest_hex_point(point_x, point_y));
				n_accepted <= n_accepted + 1;
				take_next = 1'b1;
			end
			if (take_next) begin
				if (point_queue.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
					p = point_queue.pop_front();
					point_x <= p.x;
					point_y <= p.y;
					point_valid <= 1'b1;
				end else begin
					point_valid <= 1'b0;
				end
			end
		end
	end

	// --- result side stall, with one long hold-off to back the pipe up ------

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				snap_stall <= 1'b1;
			end else if (!hold_done && n_accepted >= HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				snap_stall <= 1'b1;
			end else begin
				snap_stall <= ($urandom_range(99) < recv_idle_pct());
			end
		end
	end

	// --- monitor: compares each result with the oldest expected snap ---------

	always @(posedge clk) begin
		snap_t want;
		if (arst_n && snap_valid && !snap_stall) begin
			n_snaps <= n_snaps + 1;
			if (snap_expected.size() == 0) begin
				$display("%0t: unexpected snap a=%0d b=%0d", $time, lattice_a, lattice_b);
				n_errors++;
			end else begin
				want = snap_expected.pop_front();
				if (lattice_a !== want.a) begin
					$display("%0t: lattice_a expected %0d got %0d", $time, want.a, lattice_a);
					n_errors++;
				end
				if (lattice_b !== want.b) begin
					$display("%0t: lattice_b expected %0d got %0d", $time, want.b, lattice_b);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d items accepted, %0d snaps outstanding", $time,
				n_accepted, n_items, snap_expected.size());
			$display("hex_lattice_snap_exact_core verification failed");
			$finish;
		end
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/hlse_pkg.sv
hw/rtl/hex_lattice_snap_exact_core.sv
hw/rtl/hlse_chk.sv
verif/tb_top.sv
